[rtl/text_to_integer_parser_macros.svh]
// Assertion macros shared by the text to integer parser modules.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTIP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ttip_pkg.sv]
// Package for the text to integer parser: word types, parse state, constants.
// Depends on nothing.
package ttip_pkg;

	localparam logic [15:0] OFFSET_MAX = 16'hFFFF;
	localparam logic [5:0]  NO_DIGIT   = 6'd63;
	localparam logic [5:0]  MAX_BASE   = 6'd36;
	localparam logic [5:0]  MIN_BASE   = 6'd2;
	localparam logic [5:0]  AUTO_BASE  = 6'd0;
	localparam logic [5:0]  BASE_OCT   = 6'd8;
	localparam logic [5:0]  BASE_DEC   = 6'd10;
	localparam logic [5:0]  BASE_HEX   = 6'd16;
	localparam logic [5:0]  RADIX_RST  = 6'd10;

	localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_RADIX  = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_WS     = 7'b0000010,
		PH_SIGN   = 7'b0000100,
		PH_ZERO   = 7'b0001000,
		PH_X      = 7'b0010000,
		PH_DIGITS = 7'b0100000,
		PH_DONE   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
		logic       last;
	} byte_word_t;

	typedef struct packed {
		logic [63:0] value_bits;
		logic        converted;
		logic [15:0] end_offset;
		logic        negative;
		logic        overflow;
		logic        range_error;
	} result_word_t;

	typedef struct packed {
		logic [5:0] radix;
		logic       signed_mode;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] accum;
		logic [5:0]  active_base;
		logic        sign_seen;
		logic        overflowed;
		logic        any_digit;
		logic [15:0] byte_count;
		logic [15:0] zero_prefix_end;
	} parse_state_t;

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [5:0] d;
		d = NO_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			d = 6'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = 6'(c - CH_LA) + BASE_DEC;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = 6'(c - CH_UA) + BASE_DEC;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

[rtl/ttip_cfg.sv]
// Configuration registers of the text to integer parser behind an APB-style port.
// Depends on ttip_pkg.
module ttip_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ttip_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output ttip_pkg::cfg_t                  cfg
);

	ttip_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic           reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix       <= ttip_pkg::RADIX_RST;
			cfg_q.signed_mode <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				ttip_pkg::REG_RADIX:  cfg_q.radix       <= pwdata[5:0];
				ttip_pkg::REG_SIGNED: cfg_q.signed_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			ttip_pkg::REG_RADIX:  prdata = {26'd0, cfg_q.radix};
			ttip_pkg::REG_SIGNED: prdata = {31'd0, cfg_q.signed_mode};
			default:              prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/ttip_step.sv]
// Next-state logic for one byte: white space, sign, prefix and digit accumulation.
// Depends on ttip_pkg.
module ttip_step (
	input  ttip_pkg::byte_word_t   item,
	input  ttip_pkg::cfg_t         cfg,
	input  ttip_pkg::parse_state_t cur,
	output ttip_pkg::parse_state_t nxt,
	output logic                   emit
);

	ttip_pkg::parse_state_t st;
	logic [5:0]  d;
	logic [5:0]  tb;
	logic        start;
	logic        take;
	logic [70:0] prod;
	logic        auto_or_hex;

	assign d           = ttip_pkg::digit_of(item.ch);
	assign auto_or_hex = (cfg.radix == ttip_pkg::AUTO_BASE) || (cfg.radix == ttip_pkg::BASE_HEX);

	always_comb begin
		st    = cur;
		emit  = 1'b0;
		start = 1'b0;
		take  = 1'b0;
		tb    = cur.active_base;
		prod  = '0;
		if (item.first) begin
			st.accum           = '0;
			st.active_base     = '0;
			st.sign_seen       = 1'b0;
			st.overflowed      = 1'b0;
			st.any_digit       = 1'b0;
			st.byte_count      = '0;
			st.zero_prefix_end = '0;
			st.phase           = ttip_pkg::PH_WS;
			tb                 = '0;
		end
		if (st.phase != ttip_pkg::PH_IDLE) begin
			if (item.ch == ttip_pkg::CH_NUL) begin
				emit = 1'b1;
			end else begin
				if (st.phase != ttip_pkg::PH_DONE) begin
					if (st.byte_count != ttip_pkg::OFFSET_MAX) begin
						st.byte_count = st.byte_count + 16'd1;
					end
					priority case (st.phase)
						ttip_pkg::PH_WS: begin
							if (ttip_pkg::is_space(item.ch)) begin
							end else if (item.ch == ttip_pkg::CH_PLUS) begin
								st.phase = ttip_pkg::PH_SIGN;
							end else if (item.ch == ttip_pkg::CH_MINUS) begin
								st.sign_seen = 1'b1;
								st.phase     = ttip_pkg::PH_SIGN;
							end else begin
								start = 1'b1;
							end
						end
						ttip_pkg::PH_SIGN: start = 1'b1;
						ttip_pkg::PH_ZERO: begin
							if (item.ch == ttip_pkg::CH_LX || item.ch == ttip_pkg::CH_UX) begin
								st.phase = ttip_pkg::PH_X;
							end else begin
								take = 1'b1;
							end
						end
						ttip_pkg::PH_X: begin
							if (d < ttip_pkg::BASE_HEX) begin
								tb   = ttip_pkg::BASE_HEX;
								take = 1'b1;
							end else begin
								st.phase = ttip_pkg::PH_DONE;
							end
						end
						default: take = 1'b1;
					endcase
					if (start) begin
						if (auto_or_hex && item.ch == ttip_pkg::CH_0) begin
							st.phase           = ttip_pkg::PH_ZERO;
							st.any_digit       = 1'b1;
							st.accum           = '0;
							st.zero_prefix_end = st.byte_count;
							tb = (cfg.radix == ttip_pkg::AUTO_BASE) ? ttip_pkg::BASE_OCT
								: ttip_pkg::BASE_HEX;
						end else begin
							tb = (cfg.radix == ttip_pkg::AUTO_BASE) ? ttip_pkg::BASE_DEC
								: cfg.radix;
							if (tb < ttip_pkg::MIN_BASE || tb > ttip_pkg::MAX_BASE) begin
								st.phase = ttip_pkg::PH_DONE;
							end else begin
								take = 1'b1;
							end
						end
					end
					st.active_base = tb;
					if (take) begin
						if (tb < ttip_pkg::MIN_BASE || d >= tb) begin
							st.phase = ttip_pkg::PH_DONE;
						end else begin
							st.phase           = ttip_pkg::PH_DIGITS;
							st.any_digit       = 1'b1;
							st.zero_prefix_end = st.byte_count;
							prod = 71'(st.accum) * 71'(tb) + 71'(d);
							if (prod[70:64] != 7'd0) begin
								st.overflowed = 1'b1;
							end else if (!st.overflowed) begin
								st.accum = prod[63:0];
							end
						end
					end
				end
				if (item.last) begin
					emit = 1'b1;
				end
			end
		end
		if (emit) begin
			st.phase = ttip_pkg::PH_IDLE;
		end
	end

	assign nxt = st;

endmodule

[rtl/ttip_finish.sv]
// Result forming: saturation under unsigned or signed rules, offset and flags.
// Depends on ttip_pkg.
module ttip_finish (
	input  ttip_pkg::parse_state_t st,
	input  ttip_pkg::cfg_t         cfg,
	output ttip_pkg::result_word_t res
);

	logic [63:0] neg_accum;
	logic [63:0] v;
	logic        range_err;

	assign neg_accum = 64'd0 - st.accum;

	always_comb begin
		v         = '0;
		range_err = 1'b0;
		if (st.any_digit) begin
			if (!cfg.signed_mode) begin
				if (st.overflowed) begin
					v         = ttip_pkg::U64_MAX;
					range_err = 1'b1;
				end else begin
					v = st.sign_seen ? neg_accum : st.accum;
				end
			end else if (st.overflowed) begin
				v         = st.sign_seen ? ttip_pkg::S64_MIN : ttip_pkg::S64_MAX;
				range_err = 1'b1;
			end else if (st.sign_seen) begin
				if (st.accum > ttip_pkg::S64_MIN) begin
					v         = ttip_pkg::S64_MIN;
					range_err = 1'b1;
				end else begin
					v = neg_accum;
				end
			end else if (st.accum > ttip_pkg::S64_MAX) begin
				v         = ttip_pkg::S64_MAX;
				range_err = 1'b1;
			end else begin
				v = st.accum;
			end
		end
	end

	assign res.value_bits  = v;
	assign res.converted   = st.any_digit;
	assign res.end_offset  = st.any_digit ? st.zero_prefix_end : 16'd0;
	assign res.negative    = st.sign_seen;
	assign res.overflow    = st.any_digit && st.overflowed;
	assign res.range_error = range_err;

endmodule

[rtl/text_to_integer_parser.sv]
// Streaming text to integer parser, top level.
// Depends on ttip_pkg, ttip_cfg, ttip_step, ttip_finish and the macros header.
//
// Bytes of a numeric string enter on the byte channel, one word per byte, with
// first marking the start of a string and last (or a zero byte) its end. One
// result word leaves on the result channel for each finished string.
// A byte is accepted when byte_valid is high and byte_stall is low; a result is
// taken when result_valid is high and result_stall is low.
// An accepted byte sits in the input register, where the parse state advances by
// one multiply-add by the base; a string's result enters the output register on
// the edge at which the parse state takes its last byte, which waits in the input
// register while the output register is full and the receiver stalls.
// One byte per cycle is sustained while the output register can take results; the
// loop through the accumulator and its 64-by-6 multiply-add sets that figure.
// When the receiver stalls, the result stays in the output register; bytes that
// give no result keep flowing, and the input stalls only when a byte that ends
// a string finds the output register still full.
// Reset empties both registers, returns the parser to idle (bytes before a
// first byte are ignored), and sets radix to 10 and signed mode off.
// Configuration is to be written through the APB-style port while the block is idle; the block does not enforce it.
`include "text_to_integer_parser_macros.svh"

module text_to_integer_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ttip_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  logic                             byte_valid,
	output logic                             byte_stall,
	input  ttip_pkg::byte_word_t             byte_data,
	output logic                             result_valid,
	input  logic                             result_stall,
	output ttip_pkg::result_word_t           result_data
);

	ttip_pkg::cfg_t         cfg;
	ttip_pkg::byte_word_t   item_s1;
	logic                   valid_s1;
	ttip_pkg::parse_state_t state_q;
	ttip_pkg::parse_state_t state_nxt;
	logic                   emit;
	ttip_pkg::result_word_t res;
	ttip_pkg::result_word_t result_q;
	logic                   result_valid_q;
	logic                   out_free;
	logic                   advance;
	logic                   parse_idle;
	logic                   empty_ok;
	logic                   range_ok;

	ttip_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttip_step u_step (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.emit (emit)
	);

	ttip_finish u_finish (
		.st  (state_nxt),
		.cfg (cfg),
		.res (res)
	);

	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && (!emit || out_free);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= ttip_pkg::PH_IDLE;
			state_q.accum           <= '0;
			state_q.active_base     <= '0;
			state_q.sign_seen       <= 1'b0;
			state_q.overflowed      <= 1'b0;
			state_q.any_digit       <= 1'b0;
			state_q.byte_count      <= '0;
			state_q.zero_prefix_end <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign parse_idle = state_q.phase == ttip_pkg::PH_IDLE;
	assign empty_ok   = result_data.converted
		|| ((result_data.value_bits == 64'd0) && (result_data.end_offset == 16'd0)
		&& !result_data.overflow && !result_data.range_error);
	assign range_ok   = !result_data.range_error || result_data.converted;

	`TTIP_ASSERT(a_no_block_without_result, valid_s1 && !emit, !byte_stall, "input stalled")
	`TTIP_ASSERT_NEXT(a_idle_after_result, advance && emit, parse_idle, "parser busy")
	`TTIP_ASSERT(a_empty_result_zero, result_valid, empty_ok, "unconverted result not zero")
	`TTIP_ASSERT(a_range_needs_digit, result_valid, range_ok, "range error without digits")

endmodule

[sim/ttip_conversion_checker.sv]
`timescale 1ns / 100ps
// Conversion checker for the text to integer parser: follows the byte, result and
// register traffic, predicts every result word and compares it field by field.
// Depends on ttip_pkg for the word types, the parse phases and the character codes.
module ttip_conversion_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ttip_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	input  logic                         pready,
	input  logic                         byte_valid,
	input  logic                         byte_stall,
	input  ttip_pkg::byte_word_t         byte_data,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  ttip_pkg::result_word_t       result_data,
	output int                           outstanding,
	output int                           failures
);
	import ttip_pkg::*;

	localparam logic [PADDR_W-1:0] RADIX_ADDR  = {REG_RADIX, 2'b00};
	localparam logic [PADDR_W-1:0] SIGNED_ADDR = {REG_SIGNED, 2'b00};

	logic [5:0]   cfg_radix;
	logic         cfg_signed;
	phase_t       cur_phase;
	logic [63:0]  magnitude;
	logic [5:0]   base_now;
	logic         minus_seen;
	logic         mag_over;
	logic         digit_seen;
	logic [15:0]  taken_count;
	logic [15:0]  subject_end;

	result_word_t results_due[$];
	result_word_t got;
	result_word_t want;
	result_word_t made;
	bit           gives;
	logic [31:0]  reg_value;
	int           fail_count = 0;

	assign failures = fail_count;

	task automatic flag_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, seen, wanted, $realtime);
		fail_count++;
	endtask

	function automatic int char_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + int'(BASE_DEC);
		if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + int'(BASE_DEC);
		return int'(NO_DIGIT);
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic clear_string();
		magnitude   = '0;
		base_now    = '0;
		minus_seen  = 1'b0;
		mag_over    = 1'b0;
		digit_seen  = 1'b0;
		taken_count = '0;
		subject_end = '0;
	endtask

	task automatic take_digit_char(input logic [7:0] c);
		int          d;
		logic [63:0] b;
		d = char_value(c);
		b = 64'(base_now);
		if (base_now < MIN_BASE || d >= int'(base_now)) begin
			cur_phase = PH_DONE;
			return;
		end
		cur_phase   = PH_DIGITS;
		digit_seen  = 1'b1;
		subject_end = taken_count;
		if (magnitude > (U64_MAX - 64'(d)) / b) begin
			mag_over = 1'b1;
		end else if (!mag_over) begin
			magnitude = magnitude * b + 64'(d);
		end
	endtask

	task automatic open_subject(input logic [7:0] c);
		if ((cfg_radix == AUTO_BASE || cfg_radix == BASE_HEX) && c == CH_0) begin
			cur_phase   = PH_ZERO;
			digit_seen  = 1'b1;
			magnitude   = '0;
			subject_end = taken_count;
			base_now    = (cfg_radix == AUTO_BASE) ? BASE_OCT : BASE_HEX;
			return;
		end
		base_now = (cfg_radix == AUTO_BASE) ? BASE_DEC : cfg_radix;
		if (base_now < MIN_BASE || base_now > MAX_BASE) begin
			cur_phase = PH_DONE;
			return;
		end
		take_digit_char(c);
	endtask

	task automatic advance(input logic [7:0] c);
		if (taken_count != OFFSET_MAX) taken_count++;
		case (cur_phase)
			PH_WS: begin
				if (blank_char(c)) begin
				end else if (c == CH_PLUS) begin
					cur_phase = PH_SIGN;
				end else if (c == CH_MINUS) begin
					minus_seen = 1'b1;
					cur_phase  = PH_SIGN;
				end else begin
					open_subject(c);
				end
			end
			PH_SIGN: open_subject(c);
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) cur_phase = PH_X;
				else take_digit_char(c);
			end
			PH_X: begin
				if (char_value(c) < int'(BASE_HEX)) begin
					base_now = BASE_HEX;
					take_digit_char(c);
				end else begin
					cur_phase = PH_DONE;
				end
			end
			default: take_digit_char(c);
		endcase
	endtask

	task automatic close_result(output result_word_t r);
		r = '0;
		if (digit_seen) begin
			r.end_offset = subject_end;
			if (!cfg_signed) begin
				if (mag_over) begin
					r.value_bits  = U64_MAX;
					r.range_error = 1'b1;
				end else begin
					r.value_bits = minus_seen ? 64'd0 - magnitude : magnitude;
				end
			end else if (mag_over) begin
				r.value_bits  = minus_seen ? S64_MIN : S64_MAX;
				r.range_error = 1'b1;
			end else if (minus_seen) begin
				if (magnitude > S64_MIN) begin
					r.value_bits  = S64_MIN;
					r.range_error = 1'b1;
				end else begin
					r.value_bits = 64'd0 - magnitude;
				end
			end else if (magnitude > S64_MAX) begin
				r.value_bits  = S64_MAX;
				r.range_error = 1'b1;
			end else begin
				r.value_bits = magnitude;
			end
		end
		r.converted = digit_seen;
		r.negative  = minus_seen;
		r.overflow  = digit_seen && mag_over;
		cur_phase   = PH_IDLE;
	endtask

	task automatic predict_word(input byte_word_t w, output bit has_result,
			output result_word_t r);
		has_result = 1'b0;
		r = '0;
		if (w.first) begin
			clear_string();
			cur_phase = PH_WS;
		end
		if (cur_phase == PH_IDLE) return;
		if (w.ch == CH_NUL) begin
			close_result(r);
			has_result = 1'b1;
			return;
		end
		if (cur_phase != PH_DONE) advance(w.ch);
		if (w.last) begin
			close_result(r);
			has_result = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_due.delete();
			cfg_radix  = RADIX_RST;
			cfg_signed = 1'b0;
			cur_phase  = PH_IDLE;
			clear_string();
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = result_data;
				if (results_due.size() == 0) begin
					flag_mismatch("result word with none due", got.value_bits, '0);
				end else begin
					want = results_due.pop_front();
					if (got.value_bits !== want.value_bits)
						flag_mismatch("value_bits", got.value_bits, want.value_bits);
					if (got.converted !== want.converted)
						flag_mismatch("converted", got.converted, want.converted);
					if (got.end_offset !== want.end_offset)
						flag_mismatch("end_offset", got.end_offset, want.end_offset);
					if (got.negative !== want.negative)
						flag_mismatch("negative", got.negative, want.negative);
					if (got.overflow !== want.overflow)
						flag_mismatch("overflow", got.overflow, want.overflow);
					if (got.range_error !== want.range_error)
						flag_mismatch("range_error", got.range_error, want.range_error);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == RADIX_ADDR) cfg_radix = pwdata[5:0];
					else if (paddr == SIGNED_ADDR) cfg_signed = pwdata[0];
				end else begin
					reg_value = (paddr == RADIX_ADDR) ? 32'(cfg_radix) : 32'(cfg_signed);
					if (prdata !== reg_value) flag_mismatch("register read", prdata, reg_value);
				end
			end
			if (byte_valid && !byte_stall) begin
				predict_word(byte_data, gives, made);
				if (gives) results_due.push_back(made);
			end
			outstanding <= results_due.size();
		end
	end

endmodule

[sim/text_to_integer_parser_test.sv]
`timescale 1ns / 100ps
// Testbench top for the text to integer parser: clock, reset, register setup,
// string stimulus and the verdict. Depends on ttip_pkg, the parser and the
// conversion checker, which predicts and compares every result word.
module text_to_integer_parser_test;
	import ttip_pkg::*;

	localparam int IDLE_PCT        = 17;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 6;
	localparam int WORDS_PER_PHASE = 170;
	localparam int PHASES          = 10;
	localparam int TIMEOUT_NS      = 200_000;

	localparam logic [5:0]         BAD_BASE    = 6'd1;
	localparam logic [PADDR_W-1:0] RADIX_ADDR  = {REG_RADIX, 2'b00};
	localparam logic [PADDR_W-1:0] SIGNED_ADDR = {REG_SIGNED, 2'b00};

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [31:0]        pwdata       = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               byte_valid   = 1'b0;
	logic               byte_stall;
	byte_word_t         byte_data    = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_word_t       result_data;

	int                 outstanding;
	int                 failures;
	int                 words_sent   = 0;
	logic [5:0]         cur_radix    = RADIX_RST;
	bit                 calm         = 1'b0;
	bit                 hold_request = 1'b0;
	bit                 hold_spent   = 1'b0;
	int                 hold_left    = 0;
	logic [7:0]         text_buf[$];

	text_to_integer_parser DUT (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.byte_valid, .byte_stall, .byte_data, .result_valid, .result_stall, .result_data
	);

	ttip_conversion_checker conv_check (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.byte_valid, .byte_stall, .byte_data, .result_valid, .result_stall, .result_data,
		.outstanding, .failures
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_spent) begin
			hold_spent <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	function automatic logic [7:0] glyph(input int d);
		if (d < 10) return CH_0 + 8'(d);
		return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] blank_glyph();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] odd_glyph();
		case ($urandom_range(0, 7))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_0;
			3: return CH_LX;
			4: return CH_UX;
			5: return blank_glyph();
			6: return glyph($urandom_range(0, 35));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_word(input logic [7:0] c, input logic f, input logic l);
		byte_word_t w;
		w.ch    = c;
		w.first = f;
		w.last  = l;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= w;
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic send_buf(input bit mark_last);
		for (int i = 0; i < text_buf.size(); i++)
			send_word(text_buf[i], i == 0, mark_last && i == text_buf.size() - 1);
		words_sent += text_buf.size();
	endtask

	task automatic send_text(input string s, input bit mark_last);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
		send_buf(mark_last);
	endtask

	task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] a,
			input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic [5:0] r, input logic s);
		settle();
		apb_access(1'b1, RADIX_ADDR, 32'(r));
		apb_access(1'b1, SIGNED_ADDR, 32'(s));
		apb_access(1'b0, RADIX_ADDR, '0);
		apb_access(1'b0, SIGNED_ADDR, '0);
		cur_radix = r;
	endtask

	task automatic push_number(input int b);
		logic [63:0] v;
		logic [63:0] p;
		logic [63:0] b64;
		int          kind;
		b64  = 64'(b);
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			repeat ($urandom_range(1, kind == 5 ? 40 : 12))
				text_buf.push_back(glyph($urandom_range(0, b - 1)));
		end else begin
			case ($urandom_range(0, 5))
				0: v = S64_MAX;
				1: v = S64_MIN;
				2: v = S64_MIN + 64'd1;
				3: v = U64_MAX;
				4: v = U64_MAX - 64'($urandom_range(0, 9999));
				default: v = {$urandom, $urandom};
			endcase
			p = 64'd1;
			while (p <= v / b64) p = p * b64;
			while (p != 0) begin
				text_buf.push_back(glyph(int'(v / p)));
				v = v % p;
				p = p / b64;
			end
			if ($urandom_range(0, 2) == 0) text_buf.push_back(glyph($urandom_range(0, b - 1)));
		end
	endtask

	task automatic compose_body();
		int style;
		int n;
		int b;
		text_buf.delete();
		style = $urandom_range(0, 99);
		if (style < 70) begin
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
			repeat (n) text_buf.push_back(blank_glyph());
			case ($urandom_range(0, 2))
				1: text_buf.push_back(CH_PLUS);
				2: text_buf.push_back(CH_MINUS);
				default: ;
			endcase
			b = (cur_radix >= MIN_BASE && cur_radix <= MAX_BASE) ? int'(cur_radix)
				: int'(BASE_DEC);
			if ((cur_radix == AUTO_BASE || cur_radix == BASE_HEX)
					&& $urandom_range(0, 2) == 0) begin
				text_buf.push_back(CH_0);
				text_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
				b = int'(BASE_HEX);
			end else if (cur_radix == AUTO_BASE && $urandom_range(0, 1) == 0) begin
				text_buf.push_back(CH_0);
				b = int'(BASE_OCT);
			end
			push_number(b);
			if ($urandom_range(0, 3) == 0) text_buf.push_back(8'($urandom_range(1, 255)));
		end else if (style < 85) begin
			repeat ($urandom_range(1, 6)) text_buf.push_back(odd_glyph());
		end else begin
			repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_random_string();
		if ($urandom_range(0, 9) == 0) begin
			compose_body();
			send_buf(1'b0);
		end
		compose_body();
		if ($urandom_range(0, 9) < 7) begin
			send_buf(1'b1);
		end else begin
			send_buf(1'b0);
			send_word(CH_NUL, 1'b0, 1'($urandom_range(0, 1)));
			words_sent++;
		end
		if ($urandom_range(0, 19) == 0)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int phase_end;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(BASE_DEC, 1'b0);
		send_text("0", 1'b1);
		send_text("18446744073709551615", 1'b1);
		send_text("18446744073709551616", 1'b1);
		send_text(" \t\n\013\014\r-42", 1'b1);
		send_text("+7", 1'b1);
		send_text("-", 1'b0);
		send_word(CH_NUL, 1'b0, 1'b1);
		send_text("abc", 1'b1);
		send_text("12z9", 1'b1);
		send_word(glyph(5), 1'b0, 1'b1);
		send_text("12", 1'b0);
		send_text("34", 1'b1);
		send_text("77", 1'b0);
		send_word(CH_NUL, 1'b0, 1'b0);
		send_word(CH_NUL, 1'b1, 1'b1);
		send_text("-18446744073709551615", 1'b1);

		set_mode(AUTO_BASE, 1'b1);
		send_text("0x1F", 1'b1);
		send_text("0X", 1'b1);
		send_text("0xg", 1'b1);
		send_text("017", 1'b1);
		send_text("089", 1'b1);
		send_text("-9223372036854775808", 1'b1);
		send_text("9223372036854775808", 1'b1);
		send_text("-9223372036854775809", 1'b1);
		send_text("99999999999999999999", 1'b1);
		send_text("-0x8000000000000000", 1'b1);

		set_mode(BASE_HEX, 1'b0);
		send_text("0x", 1'b1);
		send_text("-0XfF", 1'b1);
		set_mode(MAX_BASE, 1'b1);
		send_text("-zZzzzzzzzzzzzzzzz", 1'b1);
		set_mode(MIN_BASE, 1'b0);
		send_text("1012", 1'b1);
		set_mode(BAD_BASE, 1'b0);
		send_text("-5", 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_mode(AUTO_BASE, 1'b0);
				1: set_mode(BASE_HEX, 1'b1);
				2: set_mode(MIN_BASE, 1'b1);
				3: set_mode(MAX_BASE, 1'b0);
				4: set_mode(BAD_BASE, 1'b1);
				5: set_mode(BASE_OCT, 1'b0);
				default: set_mode(6'($urandom_range(0, 36)), 1'($urandom_range(0, 1)));
			endcase
			calm = (p == 3);
			if (p == 6) hold_request = 1'b1;
			phase_end = words_sent + WORDS_PER_PHASE;
			while (words_sent < phase_end) send_random_string();
		end
		calm = 1'b0;

		settle();
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
